// ----- hw/rtl/fbal_pkg.sv -----
// Shared constants, codes and the result type of the fragment bitmap allocator.
package fbal_pkg;

  localparam int DEF_MAP_FRAGS       = 4096;
  localparam int DEF_FRAGS_PER_BLOCK = 8;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 12;
  localparam int CNT_W    = 4;
  localparam int STATUS_W = 2;
  localparam int FCNT_W   = 13;

  localparam logic [FCNT_W-1:0] FCNT_RESET = 13'd4096;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MARK_U = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MARK_F = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found;
  } res_t;

endpackage

// ----- hw/rtl/fragment_bitmap_allocator.sv -----
// Top level of the fragment bitmap allocator: configuration, result register, map memory.
//
// The block keeps one free bit per fragment and serves one request word at a
// time on the in_ channel (mode, position, count), answering each with exactly
// one result word on the out_ channel (status, found_position).
// A word moves when valid is high and stall is low at a rising clock edge.
// cfg_wr_en writes frag_count at once; it must only be written while the block idles, which the block does not enforce.
// Sequence: set-up in S_PREP and S_SET, then for scanning modes one block read
// from the map memory per step (one read port pair, one block a cycle), then
// evaluation of the last block read and closing of the scan, then read-modify-write
// in S_RD, S_WR0 and S_WR1 where the map changes, and the hand-over to the result register.
// An allocation reads every block below frag_count and inside the map, a free or mark
// reads none; a search that hits early ends sooner.
// A new request is taken in the cycle after the previous result has been handed
// to the result register, so the sender may proceed while the receiver still stalls.
// While out_stall is high the result word holds; a further finished result
// waits inside the sequencer until the register drains.
// After rst_n the memory is swept to all free, one word a cycle, over all
// (MAP_FRAGS+7)/8 words; in_stall stays high during the sweep.
module fragment_bitmap_allocator #(
  parameter int MAP_FRAGS       = fbal_pkg::DEF_MAP_FRAGS,
  parameter int FRAGS_PER_BLOCK = fbal_pkg::DEF_FRAGS_PER_BLOCK
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fbal_pkg::MODE_W-1:0]     in_mode,
  input  logic [fbal_pkg::POS_W-1:0]      in_position,
  input  logic [fbal_pkg::CNT_W-1:0]      in_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fbal_pkg::STATUS_W-1:0]   out_status,
  output logic [fbal_pkg::POS_W-1:0]      out_found_position,
  input  logic                            cfg_wr_en,
  input  logic [fbal_pkg::FCNT_W-1:0]     cfg_wr_data
);

  localparam int MAP_WORDS = (MAP_FRAGS + 7) / 8;
  localparam int AW        = $clog2(MAP_WORDS);

  logic [fbal_pkg::FCNT_W-1:0]   frag_count_r;
  logic                          out_valid_r;
  logic [fbal_pkg::STATUS_W-1:0] out_status_r;
  logic [fbal_pkg::POS_W-1:0]    out_found_r;
  fbal_pkg::res_t                res;
  logic                          res_take;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr0, rd_addr1, wr_addr;
  logic [7:0]    rd_data0, rd_data1, wr_data;

  // The result register is free when empty or when its word leaves this edge.
  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_count_r <= fbal_pkg::FCNT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frag_count_r <= cfg_wr_data;
      end
      if (res_take) begin
        out_valid_r  <= 1'b1;
        out_status_r <= res.status;
        out_found_r  <= res.found;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;

  fbal_ctl #(
    .MAP_FRAGS       (MAP_FRAGS),
    .FRAGS_PER_BLOCK (FRAGS_PER_BLOCK),
    .AW              (AW)
  ) u_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_position  (in_position),
    .in_count     (in_count),
    .frag_count   (frag_count_r),
    .res          (res),
    .res_take     (res_take),
    .mem_rd_en    (rd_en),
    .mem_rd_addr0 (rd_addr0),
    .mem_rd_addr1 (rd_addr1),
    .mem_rd_data0 (rd_data0),
    .mem_rd_data1 (rd_data1),
    .mem_wr_en    (wr_en),
    .mem_wr_addr  (wr_addr),
    .mem_wr_data  (wr_data)
  );

  fbal_mem #(
    .WORDS (MAP_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

endmodule

// ----- hw/rtl/fbal_mem.sv -----
// Free map storage: one write port and two registered read ports.
module fbal_mem #(
  parameter int WORDS = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output logic [7:0]    rd_data0,
  output logic [7:0]    rd_data1,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

// ----- hw/rtl/fbal_ctl.sv -----
// Sequencer: clearing pass, block scans and read-modify-write of the free map.
module fbal_ctl #(
  parameter int MAP_FRAGS       = fbal_pkg::DEF_MAP_FRAGS,
  parameter int FRAGS_PER_BLOCK = fbal_pkg::DEF_FRAGS_PER_BLOCK,
  parameter int AW              = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fbal_pkg::MODE_W-1:0]   in_mode,
  input  logic [fbal_pkg::POS_W-1:0]    in_position,
  input  logic [fbal_pkg::CNT_W-1:0]    in_count,
  input  logic [fbal_pkg::FCNT_W-1:0]   frag_count,
  output fbal_pkg::res_t                res,
  input  logic                          res_take,
  output logic                          mem_rd_en,
  output logic [AW-1:0]                 mem_rd_addr0,
  output logic [AW-1:0]                 mem_rd_addr1,
  input  logic [7:0]                    mem_rd_data0,
  input  logic [7:0]                    mem_rd_data1,
  output logic                          mem_wr_en,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [7:0]                    mem_wr_data
);

  localparam int MAP_WORDS = (MAP_FRAGS + 7) / 8;
  localparam int CLOG      = $clog2(MAP_FRAGS);
  localparam int FW        = ((CLOG + 2) > 14) ? (CLOG + 2) : 14;
  localparam int IW        = FW - 3;
  localparam int SH        = FW + 3;
  localparam int PWID      = FW + SH + 1;
  localparam logic [SH:0]    RECIP   = (SH+1)'(((2 ** SH) + FRAGS_PER_BLOCK - 1) / FRAGS_PER_BLOCK);
  localparam logic [FW-1:0]  FPB_F   = FW'(FRAGS_PER_BLOCK);
  localparam logic [FW-1:0]  MAP_F   = FW'(MAP_FRAGS);
  localparam logic [IW-1:0]  WORDS_I = IW'(MAP_WORDS);
  localparam logic [AW-1:0]  LAST_W  = AW'(MAP_WORDS - 1);
  localparam logic [7:0]     BMASK   = 8'((9'h1 << FRAGS_PER_BLOCK) - 9'h1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PREP = 4'd2;
  localparam logic [3:0] S_SET  = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_WR0  = 4'd6;
  localparam logic [3:0] S_WR1  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]                        state_r;
  logic [AW-1:0]                     clr_r;
  logic [fbal_pkg::MODE_W-1:0]       mode_r;
  logic [fbal_pkg::POS_W-1:0]        pos_r;
  logic [fbal_pkg::CNT_W-1:0]        cnt_r;
  logic [FW-1:0]                     qp_r, qn_r, n_r, pref_r, cur_r;
  logic                              dir_r, pend_v_r, have_r, rv_r, need1_r;
  logic [FW-1:0]                     pend_b_r, best_r, bestd_r, found_r, rs_r;
  logic [fbal_pkg::STATUS_W-1:0]     st_r;
  logic [fbal_pkg::CNT_W-1:0]        rk_r;
  logic [7:0]                        hi_r;

  logic [FW-1:0]   pos_x, fc_x, nmin, base_c, n_c, off_c, d_c, iss_b;
  logic [PWID-1:0] prod_p, prod_n;
  logic            iss, end_iss, full, better, hit;
  logic [15:0]     win16, cat, m16, new16;
  logic [7:0]      kmask8;
  logic [3:0]      run, soff;
  logic [IW-1:0]   iss_w, rs_w, rs_w1;

  always_comb begin
    pos_x  = FW'(pos_r);
    fc_x   = FW'(frag_count);
    nmin   = (fc_x > MAP_F) ? MAP_F : fc_x;
    prod_p = PWID'(pos_x) * PWID'(RECIP);
    prod_n = PWID'(nmin) * PWID'(RECIP);
    base_c = qp_r * FPB_F;
    n_c    = qn_r * FPB_F;
    off_c  = pos_x - base_c;
  end

  // Cursor: forward from the start, then (find mode only) backward from the preference.
  always_comb begin
    iss     = 1'b0;
    iss_b   = cur_r;
    end_iss = 1'b0;
    if (!dir_r) begin
      if (cur_r < n_r) begin
        iss = 1'b1;
      end else if (mode_r != fbal_pkg::MODE_FIND) begin
        end_iss = 1'b1;
      end
    end else begin
      if (cur_r >= FPB_F) begin
        iss   = 1'b1;
        iss_b = cur_r - FPB_F;
      end else begin
        end_iss = 1'b1;
      end
    end
  end

  // Evaluation of the block whose words arrived this cycle.
  always_comb begin
    cat    = {mem_rd_data1, mem_rd_data0};
    win16  = cat >> pend_b_r[2:0];
    full   = ((win16[7:0] & BMASK) == BMASK);
    d_c    = (pend_b_r > pref_r) ? (pend_b_r - pref_r) : (pref_r - pend_b_r);
    better = full && (!have_r || (d_c < bestd_r) ||
                      ((d_c == bestd_r) && (FRAGS_PER_BLOCK < 8)));
    run  = 4'd0;
    hit  = 1'b0;
    soff = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if ((i < FRAGS_PER_BLOCK) && !hit) begin
        if (win16[i]) begin
          run = run + 4'd1;
          if (run == cnt_r) begin
            hit  = 1'b1;
            soff = 4'(i + 1) - cnt_r;
          end
        end else begin
          run = 4'd0;
        end
      end
    end
    kmask8 = 8'((9'h1 << rk_r) - 9'h1);
    m16    = {8'h00, kmask8} << rs_r[2:0];
    new16  = rv_r ? (cat | m16) : (cat & ~m16);
    iss_w  = iss_b[FW-1:3];
    rs_w   = rs_r[FW-1:3];
    rs_w1  = rs_w + 1'b1;
  end

  always_comb begin
    in_stall     = (state_r != S_IDLE);
    res.valid    = (state_r == S_DONE);
    res.status   = st_r;
    res.found    = found_r[fbal_pkg::POS_W-1:0];
    mem_rd_en    = ((state_r == S_SCAN) && iss) || (state_r == S_RD);
    mem_rd_addr0 = (state_r == S_SCAN) ? iss_w[AW-1:0] : rs_w[AW-1:0];
    mem_rd_addr1 = (state_r == S_SCAN) ? AW'(iss_w + 1'b1) : rs_w1[AW-1:0];
    mem_wr_en    = 1'b0;
    mem_wr_addr  = clr_r;
    mem_wr_data  = 8'hFF;
    case (state_r)
      S_CLR: begin
        mem_wr_en = 1'b1;
      end
      S_WR0: begin
        mem_wr_en   = (rs_w < WORDS_I);
        mem_wr_addr = rs_w[AW-1:0];
        mem_wr_data = new16[7:0];
      end
      S_WR1: begin
        mem_wr_en   = need1_r;
        mem_wr_addr = rs_w1[AW-1:0];
        mem_wr_data = hi_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      pend_v_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_W) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            pos_r   <= in_position;
            cnt_r   <= in_count;
            found_r <= '0;
            st_r    <= fbal_pkg::ST_OK;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          qp_r    <= prod_p[SH +: FW];
          qn_r    <= prod_n[SH +: FW];
          state_r <= S_SET;
        end
        S_SET: begin
          n_r    <= n_c;
          pref_r <= (base_c > n_c) ? '0 : base_c;
          dir_r  <= 1'b0;
          have_r <= 1'b0;
          case (mode_r)
            fbal_pkg::MODE_ALLOC: begin
              cur_r   <= '0;
              state_r <= S_SCAN;
            end
            fbal_pkg::MODE_FREE: begin
              rs_r    <= base_c;
              rk_r    <= 4'(FRAGS_PER_BLOCK);
              rv_r    <= 1'b1;
              state_r <= S_RD;
            end
            fbal_pkg::MODE_FIND: begin
              if ((cnt_r == 4'd0) || (FW'(cnt_r) > FPB_F)) begin
                st_r    <= fbal_pkg::ST_BAD;
                state_r <= S_DONE;
              end else begin
                cur_r   <= (base_c > n_c) ? '0 : base_c;
                state_r <= S_SCAN;
              end
            end
            fbal_pkg::MODE_MARK_U, fbal_pkg::MODE_MARK_F: begin
              if ((FW'(cnt_r) > FPB_F) || ((off_c + FW'(cnt_r)) > FPB_F)) begin
                st_r    <= fbal_pkg::ST_BAD;
                state_r <= S_DONE;
              end else if (cnt_r == 4'd0) begin
                state_r <= S_DONE;
              end else begin
                rs_r    <= pos_x;
                rk_r    <= cnt_r;
                rv_r    <= (mode_r == fbal_pkg::MODE_MARK_F);
                state_r <= S_RD;
              end
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          pend_v_r <= iss;
          pend_b_r <= iss_b;
          if (iss) begin
            cur_r <= dir_r ? iss_b : (cur_r + FPB_F);
          end else if (!dir_r && !end_iss) begin
            dir_r <= 1'b1;
            cur_r <= pref_r;
          end
          if (pend_v_r && (mode_r == fbal_pkg::MODE_FIND) && hit) begin
            found_r <= pend_b_r + FW'(soff);
            state_r <= S_DONE;
          end else if (pend_v_r && (mode_r == fbal_pkg::MODE_ALLOC) && better) begin
            have_r  <= 1'b1;
            best_r  <= pend_b_r;
            bestd_r <= d_c;
          end else if (!pend_v_r && end_iss) begin
            if ((mode_r == fbal_pkg::MODE_ALLOC) && have_r) begin
              found_r <= best_r;
              rs_r    <= best_r;
              rk_r    <= 4'(FRAGS_PER_BLOCK);
              rv_r    <= 1'b0;
              state_r <= S_RD;
            end else begin
              st_r    <= fbal_pkg::ST_NONE;
              state_r <= S_DONE;
            end
          end
        end
        S_RD: begin
          state_r <= S_WR0;
        end
        S_WR0: begin
          hi_r    <= new16[15:8];
          need1_r <= (m16[15:8] != 8'h00) && (rs_w1 < WORDS_I);
          state_r <= S_WR1;
        end
        S_WR1: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_wr_en)
    else $error("map written during a scan");

  a_pend_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> $past(mem_rd_en))
    else $error("block evaluated without a read");

  a_found_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (st_r != fbal_pkg::ST_OK)) |-> (found_r == '0))
    else $error("position reported on a failed request");

endmodule

// ----- tb/fbal_scoreboard.sv -----
// Scoreboard class for the fragment bitmap allocator: predicts and checks result words.
`timescale 1ns / 100ps
class fbal_scoreboard;
  localparam int FRAGS = fbal_pkg::DEF_MAP_FRAGS;
  localparam int FPB   = fbal_pkg::DEF_FRAGS_PER_BLOCK;

  typedef struct packed {
    logic [fbal_pkg::STATUS_W-1:0] status;
    logic [fbal_pkg::POS_W-1:0]    found;
  } answer_t;

  bit              free_bits [FRAGS];
  int unsigned     frag_limit;
  answer_t         pending_answers [$];
  int              mismatch_count;

  function new();
    foreach (free_bits[i]) free_bits[i] = 1'b1;
    frag_limit = 32'(fbal_pkg::FCNT_RESET);
    mismatch_count = 0;
  endfunction

  function void set_frag_limit(logic [fbal_pkg::FCNT_W-1:0] value);
    frag_limit = 32'(value);
  endfunction

  function bit is_free(int unsigned p);
    if (p >= FRAGS) return 1'b0;
    return free_bits[p];
  endfunction

  function void put_bit(int unsigned p, bit v);
    if (p < FRAGS) free_bits[p] = v;
  endfunction

  function bit block_all_free(int unsigned b);
    for (int i = 0; i < FPB; i++) if (!is_free(b + i)) return 1'b0;
    return 1'b1;
  endfunction

  function bit run_in_block(int unsigned b, int unsigned cnt, output int unsigned start);
    int unsigned run;
    run = 0;
    start = 0;
    for (int i = 0; i < FPB; i++) begin
      if (is_free(b + i)) begin
        run++;
        if (run == cnt) begin
          start = b + i + 1 - cnt;
          return 1'b1;
        end
      end else begin
        run = 0;
      end
    end
    return 1'b0;
  endfunction

  // Notes an accepted request word and queues the answer it must produce.
  function void note_request(logic [2:0] mode, logic [11:0] position, logic [3:0] count);
    answer_t a;
    int unsigned n, pref, b, d, best, bestd, s, off;
    bit have;
    a.status = fbal_pkg::ST_OK;
    a.found = '0;
    n = (frag_limit > FRAGS) ? FRAGS : frag_limit;
    n = n - n % FPB;
    pref = position - position % FPB;
    if (pref > n) pref = 0;
    have = 1'b0;
    best = 0;
    bestd = 0;
    s = 0;
    case (mode)
      fbal_pkg::MODE_ALLOC: begin
        for (b = 0; b < n; b += FPB) begin
          if (!block_all_free(b)) continue;
          d = (b > pref) ? b - pref : pref - b;
          if (!have || d < bestd || (d == bestd && FPB < 8)) begin
            have = 1'b1;
            best = b;
            bestd = d;
          end
        end
        if (have) begin
          for (int i = 0; i < FPB; i++) put_bit(best + i, 1'b0);
          a.found = best[fbal_pkg::POS_W-1:0];
        end else begin
          a.status = fbal_pkg::ST_NONE;
        end
      end
      fbal_pkg::MODE_FREE: begin
        for (int i = 0; i < FPB; i++) put_bit(position - position % FPB + i, 1'b1);
      end
      fbal_pkg::MODE_FIND: begin
        if (count < 1 || count > FPB) begin
          a.status = fbal_pkg::ST_BAD;
        end else begin
          for (b = pref; b < n && !have; b += FPB) have = run_in_block(b, count, s);
          b = pref;
          while (!have && b >= FPB) begin
            b -= FPB;
            have = run_in_block(b, count, s);
          end
          if (have) a.found = s[fbal_pkg::POS_W-1:0];
          else a.status = fbal_pkg::ST_NONE;
        end
      end
      fbal_pkg::MODE_MARK_U, fbal_pkg::MODE_MARK_F: begin
        off = position % FPB;
        if (count > FPB || off + count > FPB) a.status = fbal_pkg::ST_BAD;
        else for (int i = 0; i < count; i++)
          put_bit(position + i, mode == fbal_pkg::MODE_MARK_F);
      end
      default: ;
    endcase
    pending_answers.push_back(a);
  endfunction

  function void check_answer(logic [1:0] status, logic [11:0] found);
    answer_t e;
    if (pending_answers.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result word: status %0d found %0d", status, found);
      return;
    end
    e = pending_answers.pop_front();
    if (e.status !== status || e.found !== found) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch: expected status %0d found %0d, got status %0d found %0d",
                 e.status, e.found, status, found);
    end
  endfunction
endclass

// ----- tb/tb_fragment_bitmap_allocator.sv -----
// Top-level testbench of the fragment bitmap allocator with stimulus and handshake drivers.
`timescale 1ns / 100ps
module tb_fragment_bitmap_allocator;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [fbal_pkg::MODE_W-1:0] in_mode = '0;
  logic [fbal_pkg::POS_W-1:0] in_position = '0;
  logic [fbal_pkg::CNT_W-1:0] in_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [fbal_pkg::STATUS_W-1:0] out_status;
  logic [fbal_pkg::POS_W-1:0] out_found_position;
  logic cfg_wr_en = 1'b0;
  logic [fbal_pkg::FCNT_W-1:0] cfg_wr_data = '0;

  fbal_scoreboard board;
  // When set, both sides run flat out so that back-to-back words are seen.
  bit no_idle = 1'b0;
  longint cycle_count = 0;
  localparam longint CYCLE_LIMIT = 4000000;

  fragment_bitmap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_position(in_position), .in_count(in_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_found_position(out_found_position),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The watchdog allows for the reset sweep and many full-map scans with stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result words are checked at the rising edge at which they are accepted.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_answer(out_status, out_found_position);
  end

  // The receiver stalls with a probability of 31 percent, except in the flat-out stretch.
  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 31);
  end

  // Drives one request word and holds it until the block takes it. Valid stays
  // high after acceptance so that a following word can go out back to back.
  task automatic send_word(logic [2:0] mode, logic [11:0] position, logic [3:0] count);
    while (!no_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_position <= position;
    in_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(mode, position, count);
    @(negedge clk);
  endtask

  // Drops valid, then waits until every expected word has arrived, plus a short pause.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_answers.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_frag_count(logic [fbal_pkg::FCNT_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_frag_limit(value);
  endtask

  // Mostly small, well-formed requests so that the map fills and empties realistically.
  task automatic random_word(int unsigned span);
    logic [2:0] mode;
    logic [11:0] pos;
    logic [3:0] cnt;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) mode = fbal_pkg::MODE_ALLOC;
    else if (r < 45) mode = fbal_pkg::MODE_FREE;
    else if (r < 65) mode = fbal_pkg::MODE_FIND;
    else if (r < 80) mode = fbal_pkg::MODE_MARK_U;
    else if (r < 95) mode = fbal_pkg::MODE_MARK_F;
    else mode = 3'($urandom_range(7));
    pos = ($urandom_range(9) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(span - 1));
    if ($urandom_range(9) == 0) begin
      cnt = 4'($urandom_range(15));
    end else begin
      cnt = 4'($urandom_range(8));
      if (mode == fbal_pkg::MODE_MARK_U || mode == fbal_pkg::MODE_MARK_F)
        cnt = 4'($urandom_range(8 - pos % 8));
    end
    send_word(mode, pos, cnt);
  endtask

  initial begin
    board = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words: extremes, every mode, ties, bad counts and ranges, unknown modes.
    send_word(fbal_pkg::MODE_ALLOC, 12'd0, 4'd0);
    send_word(fbal_pkg::MODE_ALLOC, 12'd4095, 4'd15);
    send_word(fbal_pkg::MODE_ALLOC, 12'd4, 4'd0);      // position inside an allocated block, nearest free block above
    send_word(fbal_pkg::MODE_FREE, 12'd0, 4'd0);
    send_word(fbal_pkg::MODE_MARK_U, 12'd8, 4'd8);
    send_word(fbal_pkg::MODE_ALLOC, 12'd8, 4'd0);
    send_word(fbal_pkg::MODE_MARK_U, 12'd3, 4'd6);     // range crosses a block end
    send_word(fbal_pkg::MODE_MARK_U, 12'd2, 4'd0);     // empty range
    send_word(fbal_pkg::MODE_MARK_U, 12'd1, 4'd3);
    send_word(fbal_pkg::MODE_FIND, 12'd0, 4'd5);
    send_word(fbal_pkg::MODE_FIND, 12'd0, 4'd0);       // bad count
    send_word(fbal_pkg::MODE_FIND, 12'd0, 4'd9);
    send_word(fbal_pkg::MODE_FIND, 12'd4095, 4'd8);
    send_word(fbal_pkg::MODE_MARK_F, 12'd4095, 4'd1);
    send_word(fbal_pkg::MODE_MARK_F, 12'd1, 4'd3);
    send_word(fbal_pkg::MODE_MARK_F, 12'd0, 4'd15);
    send_word(3'd5, 12'd100, 4'd1);
    send_word(3'd7, 12'd4095, 4'd15);
    send_word(fbal_pkg::MODE_FREE, 12'd4095, 4'd0);
    send_word(fbal_pkg::MODE_FREE, 12'd8, 4'd0);

    // A small map, so that searches miss and the map fills up.
    write_frag_count(13'd64);
    repeat (150) random_word(96);
    write_frag_count(13'd0);
    send_word(fbal_pkg::MODE_ALLOC, 12'd0, 4'd0);
    send_word(fbal_pkg::MODE_FIND, 12'd4, 4'd1);
    write_frag_count(13'd8191);
    repeat (150) random_word(4096);
    write_frag_count(13'd203);
    repeat (250) random_word(256);
    no_idle = 1'b1;
    repeat (150) random_word(256);
    no_idle = 1'b0;
    write_frag_count(13'd4096);
    repeat (200) random_word(4096);
    write_frag_count(13'd4);
    repeat (30) random_word(64);
    write_frag_count(13'd32);
    repeat (200) random_word(48);

    drain();
    repeat (600) @(negedge clk);
    if (board.mismatch_count == 0 && board.pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
